// ===== design/roi_dark_sum_blink_detector_top_assert.svh =====
// Assertion macros for the region dark-sum blink detector.
// Included by roi_dark_sum_blink_detector_top; depends on nothing else.
`ifndef ROI_DARK_SUM_BLINK_DETECTOR_TOP_ASSERT_SVH
`define ROI_DARK_SUM_BLINK_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RDSBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rdsbd same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RDSBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rdsbd next-cycle check failed");

`endif

// ===== design/rdsbd_pkg.sv =====
// Package for the region dark-sum blink detector.
// Holds field widths, command and register codes and default parameters.
package rdsbd_pkg;

    localparam int COL_W   = 12;
    localparam int ROW_W   = 11;
    localparam int THR_W   = 9;
    localparam int STEP_W  = 8;
    localparam int TRIG_W  = 10;
    localparam int SUM_W   = 29;
    localparam int CNT_W   = 16;
    localparam int CFG_W   = 12;
    localparam int CFG_A_W = 3;

    localparam int DEF_MAX_ROI_COLS = 2048;
    localparam int DEF_MAX_ROI_ROWS = 1024;
    localparam int DEF_CLOSED_RATIO = 5;

    localparam logic [COL_W-1:0]  RST_COL_START = 12'd630;
    localparam logic [COL_W-1:0]  RST_COL_COUNT = 12'd624;
    localparam logic [ROW_W-1:0]  RST_ROW_START = 11'd126;
    localparam logic [ROW_W-1:0]  RST_ROW_COUNT = 11'd200;
    localparam logic [THR_W-1:0]  RST_THRESHOLD = 9'd120;
    localparam logic [STEP_W-1:0] RST_STEP      = 8'd1;
    localparam logic [TRIG_W-1:0] RST_TRIGGER   = 10'd3;

    typedef enum logic [1:0] {
        CMD_PIXEL = 2'd0,
        CMD_SHUT  = 2'd1,
        CMD_OPEN  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_COL_START = 3'd0,
        CFG_COL_COUNT = 3'd1,
        CFG_ROW_START = 3'd2,
        CFG_ROW_COUNT = 3'd3,
        CFG_THRESHOLD = 3'd4,
        CFG_STEP      = 3'd5,
        CFG_TRIGGER   = 3'd6
    } t_cfg_idx;

endpackage

// ===== design/roi_dark_sum_blink_detector_top.sv =====
// Top level of the region dark-sum blink detector.
// Depends on rdsbd_pkg and roi_dark_sum_blink_detector_top_assert.svh.
//
// Input channel (i_valid / o_stall) carries one word per cycle: a command,
// a frame byte and the row and frame end marks. Sampled dark pixel words in
// the region are summed into the region total as they are accepted. Capture
// commands copy the last frame total into the shut or open reference and give
// no result. Output channel (o_valid / i_stall) gives one word per frame. The
// frame-end total is registered first; the reference compare and closed-run
// counters then load into the output register when it can advance. Throughput
// is one input word per cycle while o_stall is low. o_stall rises only when a
// frame result waits in the output register under i_stall and the next frame
// total is already pending behind it. A stalled result holds its value.
// The configuration channel is always ready and takes one register write per
// cycle; writes are meant for idle periods.
// Synchronous reset clears all counters, the running and last-frame sums and
// the references, loads the register defaults and empties both result stages.
`include "roi_dark_sum_blink_detector_top_assert.svh"

module roi_dark_sum_blink_detector_top #(
    parameter int MAX_ROI_COLS = rdsbd_pkg::DEF_MAX_ROI_COLS,
    parameter int MAX_ROI_ROWS = rdsbd_pkg::DEF_MAX_ROI_ROWS,
    parameter int CLOSED_RATIO = rdsbd_pkg::DEF_CLOSED_RATIO
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rdsbd_pkg::CFG_A_W-1:0]   i_cfg_index,
    input  logic [rdsbd_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_command,
    input  logic [7:0]                      i_pixel_byte,
    input  logic                            i_last_in_row,
    input  logic                            i_last_in_frame,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [rdsbd_pkg::SUM_W-1:0]     o_frame_sum,
    output logic                            o_eye_closed,
    output logic [rdsbd_pkg::CNT_W-1:0]     o_closed_frames,
    output logic                            o_trigger,
    output logic                            o_blink_ended,
    output logic [rdsbd_pkg::CNT_W-1:0]     o_blink_duration,
    output logic [rdsbd_pkg::CNT_W-1:0]     o_blink_total
);

    localparam int COL_W  = rdsbd_pkg::COL_W;
    localparam int ROW_W  = rdsbd_pkg::ROW_W;
    localparam int SUM_W  = rdsbd_pkg::SUM_W;
    localparam int CNT_W  = rdsbd_pkg::CNT_W;
    localparam int STEP_W = rdsbd_pkg::STEP_W;
    localparam int PRD_W  = SUM_W + 4;
    localparam logic [COL_W:0]     MAX_C   = (COL_W + 1)'(MAX_ROI_COLS);
    localparam logic [ROW_W:0]     MAX_R   = (ROW_W + 1)'(MAX_ROI_ROWS);
    localparam logic [SUM_W-1:0]   SUM_MAX = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX = '1;
    localparam logic [PRD_W-1:0]   RATIO   = PRD_W'(CLOSED_RATIO);

    logic [COL_W-1:0]                 r_col_start;
    logic [COL_W-1:0]                 r_col_count;
    logic [ROW_W-1:0]                 r_row_start;
    logic [ROW_W-1:0]                 r_row_count;
    logic [rdsbd_pkg::THR_W-1:0]      r_threshold;
    logic [STEP_W-1:0]                r_step;
    logic [rdsbd_pkg::TRIG_W-1:0]     r_trigger_cnt;

    logic [COL_W-1:0]  r_col_index, n_col_index;
    logic [ROW_W-1:0]  r_row_index, n_row_index;
    logic [STEP_W-1:0] r_col_phase, n_col_phase;
    logic [STEP_W-1:0] r_row_phase, n_row_phase;
    logic [SUM_W-1:0]  r_running_sum, n_running_sum;
    logic [SUM_W-1:0]  r_last_total;
    logic [SUM_W-1:0]  r_shut_ref;
    logic [SUM_W-1:0]  r_open_ref;
    logic [CNT_W-1:0]  r_closed_run, n_closed_run;
    logic [CNT_W-1:0]  r_blink_cnt, n_blink_cnt;

    logic              r_fe_vld;
    logic [SUM_W-1:0]  r_fe_total;
    logic              r_out_vld;

    logic              in_acc;
    logic              pix_acc;
    logic              fe_acc;
    logic              advance;
    rdsbd_pkg::t_cmd   cmd;
    logic [STEP_W-1:0] eff_step;
    logic [COL_W:0]    eff_col_cnt;
    logic [ROW_W:0]    eff_row_cnt;
    logic [COL_W-1:0]  col_off;
    logic [ROW_W-1:0]  row_off;
    logic              col_in;
    logic              row_in;
    logic              take;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  sum_sat;
    logic [STEP_W:0]   col_ph_inc;
    logic [STEP_W:0]   row_ph_inc;

    logic [SUM_W-1:0]  d_open;
    logic [SUM_W-1:0]  d_shut;
    logic [PRD_W-1:0]  d_shut_scaled;
    logic              closed;
    logic              trig;
    logic              ended;
    logic [CNT_W-1:0]  duration;

    assign o_cfg_ready = 1'b1;
    assign advance     = !r_out_vld || !i_stall;
    assign o_stall     = r_fe_vld && !advance;
    assign in_acc      = i_valid && !o_stall;
    assign cmd         = rdsbd_pkg::t_cmd'(i_command);
    assign pix_acc     = in_acc && (cmd == rdsbd_pkg::CMD_PIXEL);
    assign fe_acc      = pix_acc && i_last_in_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_start   <= rdsbd_pkg::RST_COL_START;
            r_col_count   <= rdsbd_pkg::RST_COL_COUNT;
            r_row_start   <= rdsbd_pkg::RST_ROW_START;
            r_row_count   <= rdsbd_pkg::RST_ROW_COUNT;
            r_threshold   <= rdsbd_pkg::RST_THRESHOLD;
            r_step        <= rdsbd_pkg::RST_STEP;
            r_trigger_cnt <= rdsbd_pkg::RST_TRIGGER;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (rdsbd_pkg::t_cfg_idx'(i_cfg_index))
                rdsbd_pkg::CFG_COL_START: r_col_start   <= i_cfg_data[COL_W-1:0];
                rdsbd_pkg::CFG_COL_COUNT: r_col_count   <= i_cfg_data[COL_W-1:0];
                rdsbd_pkg::CFG_ROW_START: r_row_start   <= i_cfg_data[ROW_W-1:0];
                rdsbd_pkg::CFG_ROW_COUNT: r_row_count   <= i_cfg_data[ROW_W-1:0];
                rdsbd_pkg::CFG_THRESHOLD: r_threshold   <= i_cfg_data[rdsbd_pkg::THR_W-1:0];
                rdsbd_pkg::CFG_STEP:      r_step        <= i_cfg_data[STEP_W-1:0];
                rdsbd_pkg::CFG_TRIGGER:   r_trigger_cnt <= i_cfg_data[rdsbd_pkg::TRIG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        eff_step    = (r_step == '0) ? STEP_W'(1) : r_step;
        eff_col_cnt = ({1'b0, r_col_count} > MAX_C) ? MAX_C : {1'b0, r_col_count};
        eff_row_cnt = ({1'b0, r_row_count} > MAX_R) ? MAX_R : {1'b0, r_row_count};
        col_off     = r_col_index - r_col_start;
        row_off     = r_row_index - r_row_start;
        col_in      = (r_col_index >= r_col_start) && ({1'b0, col_off} < eff_col_cnt);
        row_in      = (r_row_index >= r_row_start) && ({1'b0, row_off} < eff_row_cnt);
        take        = col_in && row_in && (r_row_phase == '0) && (r_col_phase == '0)
                      && ({1'b0, i_pixel_byte} < r_threshold);
        sum_add     = {1'b0, r_running_sum} + (SUM_W + 1)'(i_pixel_byte);
        sum_sat     = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        col_ph_inc  = {1'b0, r_col_phase} + (STEP_W + 1)'(1);
        row_ph_inc  = {1'b0, r_row_phase} + (STEP_W + 1)'(1);

        n_running_sum = take ? sum_sat : r_running_sum;
        n_col_phase   = r_col_phase;
        n_row_phase   = r_row_phase;
        n_col_index   = r_col_index + COL_W'(1);
        n_row_index   = r_row_index;
        if (col_in) begin
            n_col_phase = (col_ph_inc >= {1'b0, eff_step}) ? '0 : col_ph_inc[STEP_W-1:0];
        end
        if (i_last_in_row || i_last_in_frame) begin
            n_col_index = '0;
            n_col_phase = '0;
            n_row_index = r_row_index + ROW_W'(1);
            if (row_in) begin
                n_row_phase = (row_ph_inc >= {1'b0, eff_step}) ? '0
                              : row_ph_inc[STEP_W-1:0];
            end
        end
        if (i_last_in_frame) begin
            n_running_sum = '0;
            n_row_index   = '0;
            n_row_phase   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_index   <= '0;
            r_row_index   <= '0;
            r_col_phase   <= '0;
            r_row_phase   <= '0;
            r_running_sum <= '0;
            r_last_total  <= '0;
            r_shut_ref    <= '0;
            r_open_ref    <= '0;
        end else if (in_acc) begin
            unique case (cmd)
                rdsbd_pkg::CMD_PIXEL: begin
                    r_col_index   <= n_col_index;
                    r_row_index   <= n_row_index;
                    r_col_phase   <= n_col_phase;
                    r_row_phase   <= n_row_phase;
                    r_running_sum <= n_running_sum;
                    if (i_last_in_frame) begin
                        r_last_total <= take ? sum_sat : r_running_sum;
                    end
                end
                rdsbd_pkg::CMD_SHUT: r_shut_ref <= r_last_total;
                rdsbd_pkg::CMD_OPEN: r_open_ref <= r_last_total;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fe_vld <= 1'b0;
        end else if (fe_acc) begin
            r_fe_vld <= 1'b1;
        end else if (advance) begin
            r_fe_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe_acc) begin
            r_fe_total <= take ? sum_sat : r_running_sum;
        end
    end

    always_comb begin
        d_open        = (r_fe_total >= r_open_ref) ? (r_fe_total - r_open_ref)
                        : (r_open_ref - r_fe_total);
        d_shut        = (r_fe_total >= r_shut_ref) ? (r_fe_total - r_shut_ref)
                        : (r_shut_ref - r_fe_total);
        d_shut_scaled = PRD_W'(d_shut) * RATIO;
        closed        = PRD_W'(d_open) > d_shut_scaled;
        n_closed_run  = r_closed_run;
        n_blink_cnt   = r_blink_cnt;
        trig          = 1'b0;
        ended         = 1'b0;
        duration      = '0;
        if (closed) begin
            if (r_closed_run != CNT_MAX) begin
                n_closed_run = r_closed_run + CNT_W'(1);
                trig         = (n_closed_run == CNT_W'(r_trigger_cnt));
            end
        end else begin
            if (r_closed_run != '0) begin
                ended       = 1'b1;
                duration    = r_closed_run;
                n_blink_cnt = r_blink_cnt + CNT_W'(1);
            end
            n_closed_run = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld    <= 1'b0;
            r_closed_run <= '0;
            r_blink_cnt  <= '0;
        end else if (advance) begin
            r_out_vld <= r_fe_vld;
            if (r_fe_vld) begin
                r_closed_run <= n_closed_run;
                r_blink_cnt  <= n_blink_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_fe_vld) begin
            o_frame_sum      <= r_fe_total;
            o_eye_closed     <= closed;
            o_closed_frames  <= n_closed_run;
            o_trigger        <= trig;
            o_blink_ended    <= ended;
            o_blink_duration <= duration;
            o_blink_total    <= n_blink_cnt;
        end
    end

    assign o_valid = r_out_vld;

    `RDSBD_ASSERT_NOW(a_blink_end_open, i_clk, i_rst_n,
        o_valid && o_blink_ended, !o_eye_closed && (o_blink_duration != '0))
    `RDSBD_ASSERT_NOW(a_trigger_closed, i_clk, i_rst_n,
        o_valid && o_trigger, o_eye_closed && (o_closed_frames != '0))
    `RDSBD_ASSERT_NEXT(a_pending_held, i_clk, i_rst_n,
        r_fe_vld && r_out_vld && i_stall, r_fe_vld && r_out_vld)
    `RDSBD_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n,
        fe_acc, r_fe_vld && (r_running_sum == '0) && (r_row_index == '0))

endmodule
